### hdl/nns_pkg.sv
// Shared constants, types and pixel-mode helpers of the nearest-neighbor scaler.
package nns_pkg;

    // Frame store geometry.
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int X_IDX_W     = $clog2(MAX_WIDTH);
    localparam int Y_IDX_W     = $clog2(MAX_HEIGHT);
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths.
    localparam int COORD_W = 12;
    localparam int PIX_W   = 24;
    localparam int DIM_W   = 9;
    localparam int RATIO_W = 24;
    localparam int MODE_W  = 2;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = COORD_W + RATIO_W;
    localparam int SRC_W   = PROD_W - FRAC_W;

    // Rounding constant (one half in Q20.16) and the ratio that maps a coordinate to itself.
    localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(1) << (FRAC_W - 1);
    localparam logic [RATIO_W-1:0] UNITY_RATIO = RATIO_W'(1) << FRAC_W;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Pixel mode codes. The unused code behaves as 24 bpp.
    localparam logic [MODE_W-1:0] MODE_1BPP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_8BPP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_24BPP = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_INV_RATIO  = 2'd2;
    localparam logic [1:0] REG_PIX_MODE   = 2'd3;

    // What the mapping pipeline hands to the frame store stage.
    typedef struct packed {
        logic              rd_valid;
        logic              wr_en;
        logic              in_src;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
    } map_out_t;

    function automatic logic [PIX_W-1:0] mode_mask(input logic [MODE_W-1:0] mode);
        logic [PIX_W-1:0] m;
        unique case (mode)
            MODE_1BPP: m = PIX_W'(24'h000001);
            MODE_8BPP: m = PIX_W'(24'h0000FF);
            default:   m = PIX_W'(24'hFFFFFF);
        endcase
        return m;
    endfunction

    function automatic logic [PIX_W-1:0] fill_value(input logic [MODE_W-1:0] mode);
        logic [PIX_W-1:0] f;
        unique case (mode)
            MODE_1BPP: f = PIX_W'(24'h000001);
            MODE_8BPP: f = PIX_W'(24'h000000);
            default:   f = PIX_W'(24'hFFFFFF);
        endcase
        return f;
    endfunction

endpackage

### hdl/nns_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module nns_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/nns_coord_map.sv
// Four-stage pipeline that maps item coordinates to a frame store address and bounds flag.
module nns_coord_map import nns_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic               cmd,
    input  logic [COORD_W-1:0] coord_x,
    input  logic [COORD_W-1:0] coord_y,
    input  logic [PIX_W-1:0]   pixel_in,
    input  logic [DIM_W-1:0]   src_width,
    input  logic [DIM_W-1:0]   src_height,
    input  logic [RATIO_W-1:0] inv_ratio,
    input  logic [MODE_W-1:0]  pix_mode,
    output map_out_t           map_out
);

    // Stage 1: input capture, write data masked to the mode.
    logic               s1_valid_reg;
    logic               s1_cmd_reg;
    logic [COORD_W-1:0] s1_x_reg, s1_y_reg;
    logic [PIX_W-1:0]   s1_pix_reg;

    // Stage 2: products. A write uses unit ratio so its coordinate passes unchanged.
    logic               s2_valid_reg;
    logic               s2_cmd_reg;
    logic [PROD_W-1:0]  s2_px_reg, s2_py_reg;
    logic [PIX_W-1:0]   s2_pix_reg;
    logic [RATIO_W-1:0] ratio_sel;

    // Stage 3: rounded source coordinates.
    logic               s3_valid_reg;
    logic               s3_cmd_reg;
    logic [SRC_W-1:0]   s3_sx_reg, s3_sy_reg;
    logic [PIX_W-1:0]   s3_pix_reg;
    logic [PROD_W-1:0]  sum_x, sum_y;

    // Stage 4: bounds and address.
    map_out_t           s4_reg;
    map_out_t           s4_next;
    logic               in_store;

    assign ratio_sel = (s1_cmd_reg == CMD_READ) ? inv_ratio : UNITY_RATIO;
    assign sum_x     = s2_px_reg + ROUND_HALF;
    assign sum_y     = s2_py_reg + ROUND_HALF;

    always_comb begin
        in_store = (s3_sx_reg < SRC_W'(MAX_WIDTH)) && (s3_sy_reg < SRC_W'(MAX_HEIGHT));
        s4_next.rd_valid = s3_valid_reg && (s3_cmd_reg == CMD_READ);
        s4_next.wr_en    = s3_valid_reg && (s3_cmd_reg == CMD_WRITE) && in_store;
        s4_next.in_src   = in_store && (s3_sx_reg < SRC_W'(src_width))
                                    && (s3_sy_reg < SRC_W'(src_height));
        s4_next.addr     = ADDR_W'(ADDR_W'(s3_sy_reg[Y_IDX_W-1:0]) * ADDR_W'(MAX_WIDTH))
                         + ADDR_W'(s3_sx_reg[X_IDX_W-1:0]);
        s4_next.pix      = s3_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_reg       <= '0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_reg       <= s4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_cmd_reg    <= cmd;
            s1_x_reg      <= coord_x;
            s1_y_reg      <= coord_y;
            s1_pix_reg    <= pixel_in & mode_mask(pix_mode);
            s2_cmd_reg    <= s1_cmd_reg;
            s2_px_reg     <= PROD_W'(s1_x_reg) * PROD_W'(ratio_sel);
            s2_py_reg     <= PROD_W'(s1_y_reg) * PROD_W'(ratio_sel);
            s2_pix_reg    <= s1_pix_reg;
            s3_cmd_reg    <= s2_cmd_reg;
            s3_sx_reg     <= sum_x[PROD_W-1:FRAC_W];
            s3_sy_reg     <= sum_y[PROD_W-1:FRAC_W];
            s3_pix_reg    <= s2_pix_reg;
        end
    end

    assign map_out = s4_reg;

endmodule

### hdl/nearest_neighbor_image_scaler.sv
// Top level of the nearest-neighbor image scaler: register port, pipeline, frame store, output.
// The scaler takes one item per clock cycle, back to back. Four register stages (input capture,
// the coordinate times ratio multipliers, rounding, bounds check and address) lead a read item
// to the frame store, whose registered read data forms the output stage that holds its result.
// A write item stores one source pixel, if it falls inside the store, and gives no result. The
// whole pipeline moves together and holds, losing nothing, only while a result waits at the
// output and m_ready is low; s_ready is low in exactly those cycles. The frame store is a single
// memory of MAX_WIDTH x MAX_HEIGHT pixels with one access per cycle, needs no clearing after
// reset, and a pixel must be written before it is read. The user must write the registers only
// while no item is in flight; the block itself does not enforce this.
module nearest_neighbor_image_scaler import nns_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,

    // Item input channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [COORD_W-1:0] s_coord_x,
    input  logic [COORD_W-1:0] s_coord_y,
    input  logic [PIX_W-1:0]   s_pixel_in,

    // Result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIX_W-1:0]   m_pixel_out,
    output logic               m_in_source,

    // Register port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers.
    logic [DIM_W-1:0]   src_width_reg;
    logic [DIM_W-1:0]   src_height_reg;
    logic [RATIO_W-1:0] inv_ratio_reg;
    logic [MODE_W-1:0]  pix_mode_reg;
    logic               cfg_write;
    logic [1:0]         reg_idx;

    // Pipeline control: every stage advances unless a result is held at the output.
    logic               adv;
    map_out_t           map_out;

    // Output stage, aligned with the frame store's read data register.
    logic               out_valid_reg;
    logic               out_inside_reg;
    logic [PIX_W-1:0]   ram_rdata;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= DIM_W'(256);
            src_height_reg <= DIM_W'(256);
            inv_ratio_reg  <= UNITY_RATIO;
            pix_mode_reg   <= MODE_24BPP;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[DIM_W-1:0];
                REG_INV_RATIO:  inv_ratio_reg  <= pwdata[RATIO_W-1:0];
                REG_PIX_MODE:   pix_mode_reg   <= pwdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SRC_WIDTH:  prdata = 32'(src_width_reg);
            REG_SRC_HEIGHT: prdata = 32'(src_height_reg);
            REG_INV_RATIO:  prdata = 32'(inv_ratio_reg);
            REG_PIX_MODE:   prdata = 32'(pix_mode_reg);
            default:        prdata = 32'd0;
        endcase
    end

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    nns_coord_map u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_valid),
        .cmd        (s_cmd),
        .coord_x    (s_coord_x),
        .coord_y    (s_coord_y),
        .pixel_in   (s_pixel_in),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .inv_ratio  (inv_ratio_reg),
        .pix_mode   (pix_mode_reg),
        .map_out    (map_out)
    );

    // Each item either writes or reads the store, so one address per cycle suffices and the
    // order of accesses matches the order of items.
    nns_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (map_out.wr_en && adv),
        .waddr (map_out.addr),
        .wdata (map_out.pix),
        .re    (adv),
        .raddr (map_out.addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= map_out.rd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_inside_reg <= map_out.in_src;
        end
    end

    // A hit returns the stored pixel masked to the current mode; a miss returns the fill value.
    assign m_valid     = out_valid_reg;
    assign m_in_source = out_inside_reg;
    assign m_pixel_out = out_inside_reg ? (ram_rdata & mode_mask(pix_mode_reg))
                                        : fill_value(pix_mode_reg);

`ifndef ASSERT_OFF
    // The store is never written while a read result is held for the consumer.
    a_no_write_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(map_out.wr_en && adv))
        else $error("frame store written while output stalled");

    // An item at the store stage is a read or a write, never both.
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({map_out.rd_valid, map_out.wr_en}))
        else $error("read and write issued together");

    // In 1 bpp mode a result never carries more than one bit.
    a_1bpp_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && pix_mode_reg == MODE_1BPP) |-> (m_pixel_out[PIX_W-1:1] == '0))
        else $error("1 bpp result wider than one bit");

    // A result held for the consumer keeps its bounds flag while the pipeline is frozen.
    a_hold_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_in_source) && !$past(adv)))
        else $error("held result changed");
`endif

endmodule
